// ===== rtl/sfmf_pkg.sv =====
// shared types and constants of the substring first-match finder
// no dependencies; imported by sfmf_cell, sfmf_rsp_buf and the top level
`default_nettype none

package sfmf_pkg;

   localparam int NEEDLE_MAX   = 16;
   localparam int MAX_TEXT_LEN = 65535;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 5;
   localparam int WORD_W   = 64;
   localparam int POS_W    = 16;
   localparam int CELL_IDX_W = $clog2(NEEDLE_MAX);
   localparam int CSR_IDX_W  = 2;

   localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_LOW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_HIGH   = 2'd2;

   // per-cycle control for the cell row
   typedef struct packed {
      logic clear;    // terminator transfer: drop all partial matches
      logic advance;  // text byte transfer: step the row by one byte
   } cell_ctrl_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] match_position;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/substring_first_match_finder.sv =====
// top level of the substring first-match finder: config registers, row of cells,
// string counter and result buffer; depends on sfmf_pkg, sfmf_cell, sfmf_rsp_buf
`default_nettype none

// channel    | direction | transfer when          | contents
// -----------+-----------+------------------------+-----------------------------------
// req_*      | in        | req_tvalid & req_tready | tdata[7:0] text_byte (0 = end)
// rsp_*      | out       | rsp_tvalid & rsp_tready | tuser[0] found, tdata[15:0] position
// csr_*      | in        | csr_valid & csr_ready   | csr_index register, csr_data value
//
// one text byte per cycle while req_tready is high: each cell holds one window byte
// and hands it on at every text transfer; the match is one compare per cell, folded
// along the row; a result is registered into a two-entry buffer and offered behind any
// older entry; req_tready drops only while both entries wait
// synchronous active-high reset clears config, counter, flags, window and buffer
// csr_ready is always high; a register write applies from the next text transfer

module substring_first_match_finder (
   input  wire                            clock,
   input  wire                            reset,
   // text input
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire [7:0]                      req_tdata,   // [7:0] text_byte
   // results
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [15:0]                    rsp_tdata,   // [15:0] match_position
   output logic                           rsp_tuser,   // [0] found
   // register writes
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire [sfmf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [sfmf_pkg::WORD_W-1:0]     csr_data
);
   import sfmf_pkg::*;

   // configuration registers
   logic [LEN_W-1:0]  needle_length_ff;
   logic [WORD_W-1:0] needle_low_ff;
   logic [WORD_W-1:0] needle_high_ff;
   logic              csr_fire;

   // per-string state
   logic [POS_W-1:0]  seen_ff, seen_in;
   logic [POS_W-1:0]  seen_inc;
   logic              reported_ff, reported_in;

   // datapath
   logic                         req_fire;
   logic                         is_term;
   logic [LEN_W-1:0]             len_eff;
   logic [LEN_W-1:0]             pad_bytes;
   logic [2*WORD_W-1:0]          needle_all;
   logic [2*WORD_W-1:0]          needle_rev;
   logic [2*WORD_W-1:0]          needle_aligned;
   logic [NEEDLE_MAX*BYTE_W-1:0] window_bytes;
   logic [NEEDLE_MAX-1:0]        cell_chain;
   logic                         hit;
   logic                         empty_hit;
   logic                         reported_eff;
   cell_ctrl_type                ctrl;
   logic                         push;
   result_type                   push_data;
   result_type                   rsp_result;
   logic                         push_ready;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_length_ff <= '0;
         needle_low_ff    <= '0;
         needle_high_ff   <= '0;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_NEEDLE_LENGTH: needle_length_ff <= csr_data[LEN_W-1:0];
            CSR_NEEDLE_LOW:    needle_low_ff    <= csr_data;
            CSR_NEEDLE_HIGH:   needle_high_ff   <= csr_data;
            default:           ; // unused index, write is dropped
         endcase
      end
   end

   // lengths above the row size saturate
   assign len_eff = (needle_length_ff > LEN_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX)
                                                            : needle_length_ff;
   assign needle_all = {needle_high_ff, needle_low_ff};

   // needle reversed, then shifted so that byte len-1 sits at the newest window slot
   for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_rev
      assign needle_rev[k*BYTE_W +: BYTE_W] = needle_all[(NEEDLE_MAX-1-k)*BYTE_W +: BYTE_W];
   end
   assign pad_bytes      = LEN_W'(NEEDLE_MAX) - len_eff;
   assign needle_aligned = needle_rev >> {pad_bytes, 3'b000};

   assign req_tready = push_ready;
   assign req_fire   = req_tvalid & req_tready;
   assign is_term    = (req_tdata == TERMINATOR);

   assign ctrl.clear   = req_fire & is_term;
   assign ctrl.advance = req_fire & ~is_term;

   // cell k holds the k-th newest text byte; the chain ands the compares of the
   // window as it stands after this byte has moved in
   for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_cell
      logic [BYTE_W-1:0] byte_from_left;
      logic              prev;
      if (k == 0) begin : g_first
         assign byte_from_left = req_tdata;
         assign prev           = 1'b1;
      end else begin : g_rest
         assign byte_from_left = window_bytes[(k-1)*BYTE_W +: BYTE_W];
         assign prev           = cell_chain[k-1];
      end
      sfmf_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .text_byte   (byte_from_left),
         .needle_byte (needle_aligned[k*BYTE_W +: BYTE_W]),
         .in_use      (LEN_W'(k) < len_eff),
         .prev_match  (prev),
         .match_next  (cell_chain[k]),
         .held_byte   (window_bytes[k*BYTE_W +: BYTE_W])
      );
   end

   // saturating byte count, including the byte of this transfer
   assign seen_inc = (seen_ff != POS_W'(MAX_TEXT_LEN)) ? seen_ff + POS_W'(1) : seen_ff;

   // whole needle matches once enough bytes of this string fill the window
   assign hit = (len_eff != '0) & (seen_inc >= POS_W'(len_eff)) & cell_chain[NEEDLE_MAX-1];

   // empty needle matches at offset zero on the first item of a string
   assign empty_hit    = (len_eff == '0) & ~reported_ff & (seen_ff == '0);
   assign reported_eff = reported_ff | empty_hit;

   always_comb begin
      seen_in     = seen_ff;
      reported_in = reported_ff;
      push        = 1'b0;
      push_data.found          = 1'b0;
      push_data.match_position = '0;
      if (req_fire) begin
         if (is_term) begin
            // string end: miss unless a match went out; empty needle and string: hit
            push        = ~reported_ff;
            push_data.found = empty_hit;
            seen_in     = '0;
            reported_in = 1'b0;
         end else begin
            seen_in     = seen_inc;
            reported_in = reported_eff;
            if (empty_hit) begin
               push            = 1'b1;
               push_data.found = 1'b1;
            end else if (~reported_ff & hit) begin
               push                     = 1'b1;
               push_data.found          = 1'b1;
               push_data.match_position = seen_inc - POS_W'(len_eff);
               reported_in              = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else begin
         seen_ff     <= seen_in;
         reported_ff <= reported_in;
      end
   end

   sfmf_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = rsp_result.match_position;
   assign rsp_tuser = rsp_result.found;

   // a terminator leaves a clean string state behind
   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_term) |=> (seen_ff == '0 && !reported_ff && window_bytes == '0))
      else $error("string state not cleared after terminator");

   // once a result went out for a string, only a terminator may drop the flag
   a_reported_holds: assert property (@(posedge clock) disable iff (reset)
      (reported_ff && !(req_fire && is_term)) |=> reported_ff)
      else $error("match flag dropped inside a string");

   // a reported start offset never lies beyond the bytes counted so far
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      push |-> (req_fire && push_data.match_position <= seen_in))
      else $error("result pushed without a transfer or with offset past count");

endmodule

`default_nettype wire

// ===== rtl/sfmf_cell.sv =====
// one cell of the text window: holds one recent byte and checks it against the needle
// depends on sfmf_pkg
`default_nettype none

module sfmf_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  sfmf_pkg::cell_ctrl_type      ctrl,
   input  wire [sfmf_pkg::BYTE_W-1:0]   text_byte,    // byte entering this cell on an advance
   input  wire [sfmf_pkg::BYTE_W-1:0]   needle_byte,  // needle byte aligned to this position
   input  wire                          in_use,       // position lies inside the needle
   input  wire                          prev_match,
   output logic                         match_next,
   output logic [sfmf_pkg::BYTE_W-1:0]  held_byte
);
   import sfmf_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   // positions past the needle end always agree; the rest compare the shifted-in byte
   assign match_next = prev_match & (~in_use | (text_byte == needle_byte));

   always_comb begin
      byte_in = byte_ff;
      if (ctrl.clear) begin
         byte_in = '0;
      end else if (ctrl.advance) begin
         byte_in = text_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign held_byte = byte_ff;

endmodule

`default_nettype wire

// ===== rtl/sfmf_rsp_buf.sv =====
// two-entry result buffer between the match logic and the result channel
// depends on sfmf_pkg
`default_nettype none

module sfmf_rsp_buf (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push_valid,
   input  sfmf_pkg::result_type    push_data,
   output logic                    push_ready,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output sfmf_pkg::result_type    rsp_result
);
   import sfmf_pkg::*;

   result_type  entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_result = entry_ff[rd_ptr_ff];

   assign push = push_valid & push_ready;
   assign pop  = rsp_tvalid & rsp_tready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // occupancy must agree with the pointer distance
   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("result buffer count and pointers disagree");

endmodule

`default_nettype wire
